// ===== rtl/ddo_pkg.sv =====
// Shared types and constants for the differential-drive odometry block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ddo_pkg;

  // Position and rotation widths
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned STEP_W     = 40;
  localparam int unsigned XW         = 52;   // CORDIC x/y, step << guard plus growth
  localparam int unsigned ZW         = 34;   // CORDIC residual angle
  localparam int unsigned ITER_W     = 5;    // index into the 32-entry arctangent table

  // Inverse CORDIC gain, Q0.32
  localparam logic [31:0] CORDIC_K = 32'd2608131496;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_UPDATE      = 2'd0,
    OP_LOAD_X      = 2'd1,
    OP_LOAD_Y      = 2'd2,
    OP_SET_HEADING = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_MPT     = 2'd1,
    CFG_APT     = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  // Operand select for the shared multiplier
  typedef enum logic [1:0] {
    MUL_ANG  = 2'd0,
    MUL_STEP = 2'd1,
    MUL_KLO  = 2'd2,
    MUL_KHI  = 2'd3
  } mul_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic              capture;    // latch input transaction
    logic              dispatch;   // mean change, X/Y loads
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              ang_upd;    // heading or heading offset
    logic              step_form;  // saturated distance step
    logic              kl_save;
    logic              rot_init;
    logic              rot;
    logic [ITER_W-1:0] iter;
    logic              acc;
    logic              out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic enabled;
  } status_t;

  // Arctangent table, binary-angle units
  function automatic logic [31:0] atan_fn(input logic [ITER_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ddo_ctrl.sv =====
// Sequencing state machine for the odometry block.
// Depends on ddo_pkg; drives the datapath through cmd_t and owns the handshakes.
`default_nettype none

module ddo_ctrl import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output logic         cfg_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DISP = 10'b0000000010,
    S_AN   = 10'b0000000100,
    S_ST   = 10'b0000001000,
    S_KL   = 10'b0000010000,
    S_KH   = 10'b0000100000,
    S_X0   = 10'b0001000000,
    S_ROT  = 10'b0010000000,
    S_ACC  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              oval_q, oval_d;
  logic              accept;
  logic              rot_last;
  logic              out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = oval_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign rot_last    = (iter_q == ITER_W'(CORDIC_STEPS - 1));
  assign out_free    = !oval_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.iter = iter_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.dispatch = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_ANG;
        if (status_i.op == OP_LOAD_X || status_i.op == OP_LOAD_Y ||
            (status_i.op == OP_UPDATE && !status_i.enabled)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_AN;
        end
      end
      S_AN: begin
        cmd_o.ang_upd = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_STEP;
        state_d = (status_i.op == OP_SET_HEADING) ? S_DONE : S_ST;
      end
      S_ST: begin
        cmd_o.step_form = 1'b1;
        state_d = S_KL;
      end
      S_KL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KLO;
        state_d = S_KH;
      end
      S_KH: begin
        cmd_o.kl_save = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_KHI;
        state_d = S_X0;
      end
      S_X0: begin
        cmd_o.rot_init = 1'b1;
        iter_d  = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        iter_d = iter_q + 1'b1;
        if (rot_last) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          oval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      oval_q  <= oval_d;
    end
  end

  // A new transaction always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISP)
    else $error("accepted transaction did not start");

  // Rotation runs its full count
  a_rot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT && !rot_last) |=> state_q == S_ROT)
    else $error("rotation left early");

  // Result is presented when done completes
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (oval_q && state_q == S_IDLE))
    else $error("result not presented");

  // Work states never overlap an input handshake
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input open while busy");

endmodule

`default_nettype wire

// ===== rtl/ddo_datapath.sv =====
// Odometry datapath: config registers, shared 32x32 multiplier, iterative CORDIC,
// saturating accumulators and result register. Depends on ddo_pkg.
`default_nettype none

module ddo_datapath import ddo_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] left_count_i,
  input  wire logic [31:0] right_count_i,
  input  wire logic [31:0] load_value_i,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      heading_o
);

  localparam int unsigned SH = 32 - POS_FRAC_BITS;

  // Config and architectural state
  logic               en_q;
  logic [31:0]        mpt_q, apt_q;
  logic [31:0]        last_q, xacc_q, yacc_q, head_q, off_q;
  // Working registers
  op_e                op_q;
  logic [31:0]        load_q;
  logic signed [32:0] sum_q, diff_q, d_q;
  logic [63:0]        mul_q;
  logic [STEP_W-1:0]  step_q;
  logic [31:0]        kl_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [31:0]        ox_q, oy_q, oh_q;

  logic signed [32:0] sum_d, diff_d, mean, d_d;
  logic [32:0]        mag;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_d;
  logic [47:0]        ang_t;
  logic [31:0]        angle;
  logic [64:0]        prod;
  logic [STEP_W-1:0]  step_d;
  logic [40:0]        scaled;
  logic               fold, neg;
  logic signed [XW-1:0] x0, xs, ys, sx, sy;
  logic signed [ZW-1:0] z0, atan_z;
  logic [31:0]        hf;

  assign status_o.op      = op_q;
  assign status_o.enabled = en_q;
  assign pos_x_o   = ox_q;
  assign pos_y_o   = oy_q;
  assign heading_o = oh_q;

  // Sum and difference of the counts
  assign sum_d  = {left_count_i[31], left_count_i} + {right_count_i[31], right_count_i};
  assign diff_d = {right_count_i[31], right_count_i} - {left_count_i[31], left_count_i};
  // Mean truncated toward zero, change since last update
  assign mean = $signed(sum_q + {32'b0, sum_q[32]}) >>> 1;
  assign d_d  = mean - {last_q[31], last_q};
  assign mag  = d_q[32] ? 33'(-d_q) : 33'(d_q);

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ANG:  begin mul_a = diff_q[31:0];             mul_b = apt_q;    end
      MUL_STEP: begin mul_a = mag[31:0];                mul_b = mpt_q;    end
      MUL_KLO:  begin mul_a = step_q[31:0];             mul_b = CORDIC_K; end
      MUL_KHI:  begin mul_a = {24'b0, step_q[39:32]};   mul_b = CORDIC_K; end
      default:  begin mul_a = '0;                       mul_b = '0;       end
    endcase
  end
  assign mul_d = mul_a * mul_b;

  // Angle of the wheel difference; the sign word contributes -apt << 32
  assign ang_t = mul_q[47:0] - (diff_q[32] ? {apt_q[15:0], 32'b0} : 48'b0);
  assign angle = ang_t[47:16];

  // Distance step with saturation
  assign prod   = {1'b0, mul_q} + (mag[32] ? {1'b0, mpt_q, 32'b0} : 65'b0);
  assign step_d = (|prod[64:SH+STEP_W]) ? '1 : prod[SH+STEP_W-1:SH];

  // Scaled start vector and half-plane fold
  assign scaled = {1'b0, mul_q[39:0]} + {9'b0, kl_q};
  assign fold   = ($signed(head_q) > 32'sh40000000) || ($signed(head_q) < -32'sh40000000);
  assign neg    = d_q[32] ^ fold;
  assign x0     = $signed(XW'(scaled)) <<< GUARD_BITS;
  assign hf     = head_q + 32'h80000000;
  assign z0     = fold ? ZW'($signed(hf)) : ZW'($signed(head_q));

  // One CORDIC step
  assign xs     = x_q >>> cmd_i.iter;
  assign ys     = y_q >>> cmd_i.iter;
  assign atan_z = $signed({2'b0, atan_fn(cmd_i.iter)});

  // Guard bits dropped before accumulation
  assign sx = x_q >>> GUARD_BITS;
  assign sy = y_q >>> GUARD_BITS;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [XW-1:0] b);
    logic signed [XW:0] s;
    s = $signed({{(XW-31){a[31]}}, a}) + $signed({b[XW-1], b});
    if (s > $signed((XW+1)'(32'h7FFFFFFF))) begin
      return 32'h7FFFFFFF;
    end else if (s < -$signed((XW+1)'(33'h080000000))) begin
      return 32'h80000000;
    end
    return s[31:0];
  endfunction

  // Config and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      mpt_q  <= '0;
      apt_q  <= '0;
      last_q <= '0;
      xacc_q <= '0;
      yacc_q <= '0;
      head_q <= '0;
      off_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ENABLED: en_q  <= cfg_data_i[0];
          CFG_MPT:     mpt_q <= cfg_data_i;
          CFG_APT:     apt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.dispatch) begin
        if (op_q == OP_LOAD_X) begin
          xacc_q <= load_q;
          en_q   <= 1'b1;
        end else if (op_q == OP_LOAD_Y) begin
          yacc_q <= load_q;
          en_q   <= 1'b1;
        end
      end
      if (cmd_i.ang_upd) begin
        if (op_q == OP_SET_HEADING) begin
          off_q <= load_q - angle;
          en_q  <= 1'b1;
        end else begin
          head_q <= off_q + angle;
        end
      end
      if (cmd_i.rot_init) begin
        last_q <= mean[31:0];
      end
      if (cmd_i.acc) begin
        xacc_q <= sat_add(xacc_q, sx);
        yacc_q <= sat_add(yacc_q, sy);
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      load_q <= load_value_i;
      sum_q  <= sum_d;
      diff_q <= diff_d;
    end
    if (cmd_i.dispatch) begin
      d_q <= d_d;
    end
    if (cmd_i.mul_en) begin
      mul_q <= mul_d;
    end
    if (cmd_i.step_form) begin
      step_q <= step_d;
    end
    if (cmd_i.kl_save) begin
      kl_q <= mul_q[63:32];
    end
    if (cmd_i.rot_init) begin
      x_q <= neg ? -x0 : x0;
      y_q <= '0;
      z_q <= z0;
    end else if (cmd_i.rot) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_z;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_z;
      end
    end
    if (cmd_i.out_load) begin
      ox_q <= xacc_q;
      oy_q <= yacc_q;
      oh_q <= head_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/differential_drive_odometry.sv =====
// Differential-drive odometry: one result per input transaction, state after it.
// Loads and disabled updates go from dispatch to done, set heading ends after the
// angle state, an enabled update adds step, gain, CORDIC and accumulate states on
// the single shared 32x32 multiplier. One transaction is in flight; a finished
// result waits in the output register while the next transaction is accepted.
// Async active-low reset clears config, pose and control state; no clearing pass.
`default_nettype none

module differential_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS  = 24,
  parameter int unsigned POS_FRAC_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] left_count_i,
  input  wire logic [31:0] right_count_i,
  input  wire logic [31:0] load_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      heading_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  ddo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_ready_o(cfg_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddo_datapath #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .left_count_i (left_count_i),
    .right_count_i(right_count_i),
    .load_value_i (load_value_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .heading_o    (heading_o)
  );

endmodule

`default_nettype wire

// ===== bench/differential_drive_odometry_tb.sv =====
// Self-checking testbench for differential_drive_odometry: predicts pose after each
// transaction with an in-bench odometry model and compares every result in order.
// Depends on ddo_pkg (op and config index enums) and the RTL top level.
`default_nettype none

module differential_drive_odometry_tb import ddo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS     = 24;
  localparam int unsigned FRAC      = 20;
  localparam longint      MAX_CYC   = 4000000;

  // Expected pose after one transaction
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
  } pose_t;

  // Odometry predictor plus in-order store of expected poses
  class pose_board;
    bit          en;
    logic [31:0] mpt, apt;
    logic [31:0] last_mean, xa, ya, hdg, hoff;
    pose_t       pending[$];
    int          errors;

    function void clear();
      en = 0; mpt = 0; apt = 0;
      last_mean = 0; xa = 0; ya = 0; hdg = 0; hoff = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_ENABLED: en = val[0];
        CFG_MPT:     mpt = val;
        CFG_APT:     apt = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] wheel_angle(longint dif);
      logic [63:0] p;
      p = 64'(dif) * {32'd0, apt};
      return p[47:16];
    endfunction

    function logic [31:0] sat32(logic [31:0] a, longint b);
      longint s;
      s = longint'(signed'(a)) + b;
      if (s > 64'sd2147483647) return 32'h7fffffff;
      if (s < -64'sd2147483648) return 32'h80000000;
      return s[31:0];
    endfunction

    function void advance(longint l, longint r);
      longint mean, d, x, y, z, xs, ys;
      logic [63:0] mag, stp, scl;
      logic [31:0] ang, at;
      mean = (l + r) / 2;
      d = mean - longint'(signed'(last_mean));
      hdg = hoff + wheel_angle(r - l);
      mag = (d < 0) ? -d : d;
      stp = (mag * {32'd0, mpt}) >> (32 - FRAC);
      if (stp > 64'hff_ffff_ffff) stp = 64'hff_ffff_ffff;
      scl = (stp >> 32) * 64'(CORDIC_K) + (((stp & 64'hffff_ffff) * 64'(CORDIC_K)) >> 32);
      x = longint'(scl << GUARD_BITS);
      if (d < 0) x = -x;
      y = 0;
      ang = hdg;
      z = longint'(signed'(ang));
      if (z > 64'sh4000_0000 || z < -64'sh4000_0000) begin
        x = -x;
        z = longint'(signed'(ang + 32'h8000_0000));
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        at = atan_fn(i[ITER_W-1:0]);
        if (z >= 0) begin
          x = x - ys; y = y + xs; z -= longint'(at);
        end else begin
          x = x + ys; y = y - xs; z += longint'(at);
        end
      end
      xa = sat32(xa, x >>> GUARD_BITS);
      ya = sat32(ya, y >>> GUARD_BITS);
      last_mean = mean[31:0];
    endfunction

    // Note an accepted input transaction
    function void note_input(op_e op, logic [31:0] l, logic [31:0] r, logic [31:0] ld);
      pose_t p;
      longint ls, rs;
      ls = longint'(signed'(l));
      rs = longint'(signed'(r));
      case (op)
        OP_UPDATE:      if (en) advance(ls, rs);
        OP_LOAD_X:      begin xa = ld; en = 1; end
        OP_LOAD_Y:      begin ya = ld; en = 1; end
        OP_SET_HEADING: begin hoff = ld - wheel_angle(rs - ls); en = 1; end
        default: ;
      endcase
      p.x = xa; p.y = ya; p.hdg = hdg;
      pending.push_back(p);
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] h);
      pose_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h heading=%h", $time, x, y, h);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $display("%0t: pos_x expected %h actual %h", $time, e.x, x); errors++;
      end
      if (y !== e.y) begin
        $display("%0t: pos_y expected %h actual %h", $time, e.y, y); errors++;
      end
      if (h !== e.hdg) begin
        $display("%0t: heading expected %h actual %h", $time, e.hdg, h); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [31:0] left_count_i = '0, right_count_i = '0, load_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [31:0] pos_x_o, pos_y_o, heading_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  pose_board   board;
  longint      cycles = 0;
  bit          stall_mode = 1;
  logic [31:0] cur_l = 0, cur_r = 0;

  differential_drive_odometry #(.CORDIC_STEPS(STEPS), .POS_FRAC_BITS(FRAC)) u_top (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Short gaps mostly, a long one now and then
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result monitor and receiver stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(pos_x_o, pos_y_o, heading_o);
    if (!stall_mode) begin
      out_stall_i <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1;
    end else begin
      stall_left <= gap_len();
      out_stall_i <= 0;
    end
  end

  // Valid stays up after acceptance until the next gap or drain drops it
  task automatic send(op_e op, logic [31:0] l, logic [31:0] r, logic [31:0] ld, bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= op; left_count_i <= l; right_count_i <= r; load_value_i <= ld;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(op, l, r, ld);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
  endtask

  task automatic set_ratios(logic [31:0] mpt, logic [31:0] apt, logic en);
    drain();
    write_reg(CFG_MPT, mpt);
    write_reg(CFG_APT, apt);
    write_reg(CFG_ENABLED, {31'd0, en});
    cfg_valid_i <= 0;
  endtask

  // Well-formed motion: counts move by small wheel steps, with odd jumps and loads
  task automatic random_phase(int n);
    int k;
    op_e op;
    logic [31:0] ld;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      ld = $urandom;
      if (k < 78) begin
        op = OP_UPDATE;
        cur_l = cur_l + $signed($urandom_range(0, 400)) - 200;
        cur_r = cur_r + $signed($urandom_range(0, 400)) - 200;
      end else if (k < 84) begin
        op = OP_UPDATE;
        cur_l = $urandom;
        cur_r = $urandom;
      end else begin
        op = op_e'($urandom_range(1, 3));
        if (op != OP_SET_HEADING) ld = $signed(ld) >>> $urandom_range(0, 12);
      end
      send(op, cur_l, cur_r, ld, 1);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: disabled update, zero ratios, loads enabling, extremes
    send(OP_UPDATE, 32'd100, 32'd300, 32'd0, 0);
    send(OP_LOAD_X, 32'd0, 32'd0, 32'h0000_1000, 0);
    send(OP_UPDATE, 32'd50, 32'd90, 32'd0, 0);
    set_ratios(32'h0100_0000, 32'h0001_0000, 1);
    send(OP_LOAD_Y, 32'd0, 32'd0, 32'h8000_0000, 0);
    send(OP_LOAD_X, 32'd0, 32'd0, 32'h7fff_ffff, 0);
    send(OP_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 0);
    send(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'd0, 0);
    send(OP_SET_HEADING, 32'h8000_0000, 32'h7fff_ffff, 32'h4000_0000, 0);
    send(OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 0);
    send(OP_UPDATE, 32'd1, 32'hffff_fffe, 32'hffff_ffff, 0);
    send(OP_LOAD_X, 32'd0, 32'd0, 32'd0, 0);
    send(OP_LOAD_Y, 32'd0, 32'd0, 32'd0, 0);
    set_ratios(32'hffff_ffff, 32'hffff_ffff, 1);
    send(OP_UPDATE, 32'h7fff_ffff, 32'h8000_0001, 32'd0, 0);
    send(OP_UPDATE, 32'hffff_ffff, 32'd3, 32'd0, 0);
    send(OP_SET_HEADING, 32'd5, 32'd7, 32'hc000_0000, 0);
    send(OP_UPDATE, 32'd5, 32'd7, 32'd0, 0);
    set_ratios(32'h0000_0000, 32'h0000_0000, 0);
    send(OP_UPDATE, 32'd9, 32'd99, 32'd0, 0);

    // Random phases over several ratio settings
    set_ratios(32'h0010_0000, 32'h0080_0000, 1);
    random_phase(300);
    set_ratios($urandom, $urandom, 1);
    random_phase(300);
    drain();                  // sender holds until the pipeline is empty
    stall_mode = 0;
    set_ratios(32'hffff_ffff, $urandom, 1);
    random_phase(250);
    stall_mode = 1;
    set_ratios($urandom_range(0, 32'h00ff_ffff), 32'hffff_ffff, 0);
    random_phase(250);
    set_ratios($urandom, $urandom_range(0, 32'h0fff_ffff), 1);
    random_phase(450);

    drain();
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
